/* design/seven_bit_group_integer_codec_unit_macros.svh */
// assertion macros for the seven-bit group integer codec
`ifndef SEVEN_BIT_GROUP_INTEGER_CODEC_UNIT_MACROS_SVH
`define SEVEN_BIT_GROUP_INTEGER_CODEC_UNIT_MACROS_SVH

// same-cycle implication, disabled during reset
`define SBGIC_ASSERT_IMPLY(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define SBGIC_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/sbgic_pkg.sv */
// shared types, constants and helper functions of the seven-bit group codec
package sbgic_pkg;

    localparam int DATA_BITS       = 64;
    localparam int CODE_BITS       = 8;
    localparam int GROUP_BITS      = 7;
    localparam int CFG_BITS        = 7;
    localparam int COUNT_BITS      = 7;
    localparam int TDATA_BITS      = DATA_BITS + CODE_BITS;
    localparam int VALUE_BITS_DEF  = 64;

    localparam logic [CFG_BITS-1:0]   RESULT_BITS_RESET = 7'd64;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX         = 7'd127;

    localparam logic OP_ENCODE = 1'b0;
    localparam logic OP_DECODE = 1'b1;

    localparam logic [CODE_BITS-1:0] HALVING_MASKS [3] = '{8'hF0, 8'hCC, 8'hAA};

    typedef struct packed {
        logic                 valid;
        logic [CODE_BITS-1:0] code;
        logic                 last;
    } enc_out_t;

    typedef struct packed {
        logic                 valid;
        logic [DATA_BITS-1:0] value;
        logic                 overflow;
    } dec_res_t;

    // bit length of a nonzero group by halving search
    function automatic logic [2:0] group_length(input logic [GROUP_BITS-1:0] grp);
        logic [CODE_BITS-1:0] g;
        logic [2:0]           len;
        g   = {1'b0, grp};
        len = 3'd0;
        for (int m = 0; m < 3; m++) begin
            if ((g & HALVING_MASKS[m]) != '0) begin
                g   = g & HALVING_MASKS[m];
                len = len | 3'(4 >> m);
            end else begin
                g   = g & ~HALVING_MASKS[m];
            end
        end
        return len + 3'd1;
    endfunction

endpackage

/* design/sbgic_enc.sv */
// encoder: shifts the value out one 7-bit group per cycle while take is high, leading zero groups skipped
module sbgic_enc #(
    parameter int VALUE_BITS = sbgic_pkg::VALUE_BITS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           load,
    input  logic [sbgic_pkg::DATA_BITS-1:0] value,
    input  logic                           take,
    output sbgic_pkg::enc_out_t            out,
    output logic                           busy
);

    localparam int GB     = sbgic_pkg::GROUP_BITS;
    localparam int NGROUPS = (VALUE_BITS + GB - 1) / GB;
    localparam int SH_W   = NGROUPS * GB;
    localparam int CNT_W  = $clog2(NGROUPS + 1);

    logic [SH_W-1:0]  sh_reg, sh_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             first_reg, first_next;
    logic             busy_reg, busy_next;
    logic [GB-1:0]    top_grp;
    logic             skip;

    always_comb begin
        top_grp    = sh_reg[SH_W-1 -: GB];
        skip       = busy_reg && first_reg && (top_grp == '0) && (cnt_reg > CNT_W'(1));
        out.valid  = busy_reg && !skip;
        out.code   = {~first_reg, top_grp};
        out.last   = (cnt_reg == CNT_W'(1));

        sh_next    = sh_reg;
        cnt_next   = cnt_reg;
        first_next = first_reg;
        busy_next  = busy_reg;
        if (load) begin
            sh_next    = SH_W'(value[VALUE_BITS-1:0]);
            cnt_next   = CNT_W'(NGROUPS);
            first_next = 1'b1;
            busy_next  = 1'b1;
        end else if (skip || (out.valid && take)) begin
            sh_next  = {sh_reg[SH_W-GB-1:0], {GB{1'b0}}};
            cnt_next = cnt_reg - CNT_W'(1);
            if (!skip) begin
                first_next = 1'b0;
                if (out.last) begin
                    busy_next = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
        end
        sh_reg    <= sh_next;
        cnt_reg   <= cnt_next;
        first_reg <= first_next;
    end

    assign busy = busy_reg;

endmodule

/* design/sbgic_dec.sv */
// decoder: shifts in one 7-bit group per request and tracks significant bits
module sbgic_dec #(
    parameter int VALUE_BITS = sbgic_pkg::VALUE_BITS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                take,
    input  logic [sbgic_pkg::GROUP_BITS-1:0]    grp,
    input  logic                                is_last,
    input  logic [sbgic_pkg::CFG_BITS-1:0]      result_bits,
    output sbgic_pkg::dec_res_t                 res
);

    localparam int GB = sbgic_pkg::GROUP_BITS;
    localparam int CB = sbgic_pkg::COUNT_BITS;

    logic [VALUE_BITS-1:0] acc_reg, acc_next, acc_shift, mask;
    logic [CB-1:0]         cnt_reg, cnt_next, cnt_new;
    logic [CB:0]           cnt_sum;
    logic [CB-1:0]         width;

    always_comb begin
        acc_shift = {acc_reg[VALUE_BITS-GB-1:0], grp};
        cnt_sum   = {1'b0, cnt_reg} + (CB+1)'(GB);
        if (cnt_reg == '0) begin
            cnt_new = (grp != '0) ? CB'(sbgic_pkg::group_length(grp)) : '0;
        end else if (cnt_sum > {1'b0, sbgic_pkg::COUNT_MAX}) begin
            cnt_new = sbgic_pkg::COUNT_MAX;
        end else begin
            cnt_new = cnt_sum[CB-1:0];
        end

        priority if (result_bits == '0) begin
            width = CB'(1);
        end else if (result_bits > CB'(VALUE_BITS)) begin
            width = CB'(VALUE_BITS);
        end else begin
            width = result_bits;
        end
        for (int i = 0; i < VALUE_BITS; i++) begin
            mask[i] = (CB'(i) < width);
        end

        res.valid    = take && is_last;
        res.value    = sbgic_pkg::DATA_BITS'(acc_shift & mask);
        res.overflow = (cnt_new > width);

        acc_next = acc_reg;
        cnt_next = cnt_reg;
        if (take) begin
            if (is_last) begin
                acc_next = '0;
                cnt_next = '0;
            end else begin
                acc_next = acc_shift;
                cnt_next = cnt_new;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg <= '0;
            cnt_reg <= '0;
        end else begin
            acc_reg <= acc_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

/* design/seven_bit_group_integer_codec_unit.sv */
// top level of the seven-bit group integer codec
// usage:
//   s_* carries requests: tuser[0] selects encode (0) or decode (1), tdata holds
//   the value to encode in bits 63:0 and the byte to decode in bits 71:64, tlast
//   marks the final byte of an encoded sequence.
//   m_* carries results: tdata holds the code byte in bits 7:0 and the decoded
//   value in bits 71:8, tuser[0] is the overflow flag, tlast ends each run.
//   cfg_we/cfg_wdata set the decode result width (0 acts as 1, above VALUE_BITS
//   acts as VALUE_BITS); write it only while idle.
// timing:
//   decode takes one byte per cycle while s_tready is high; the result of a final
//   byte shows on m_* the cycle after its request.
//   encode occupies the encoder from the cycle after the request: it first skips
//   the leading zero groups, then sends one byte per cycle while the output
//   register is free; each code byte is registered in the output register before
//   it shows on m_*.
//   a new request is taken once the encoder is done and the output register is free.
// reset clears the decode state and the output valid flag and sets the width to 64.
// when m_tvalid is high and m_tready is low the output register holds and s_tready drops.
module seven_bit_group_integer_codec_unit #(
    parameter int VALUE_BITS = sbgic_pkg::VALUE_BITS_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_we,
    input  logic [sbgic_pkg::CFG_BITS-1:0]       cfg_wdata,   // result_bits
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [sbgic_pkg::TDATA_BITS-1:0]     s_tdata,     // value_in, byte_in
    input  logic                                 s_tlast,
    input  logic [0:0]                           s_tuser,     // opcode
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [sbgic_pkg::TDATA_BITS-1:0]     m_tdata,     // code_byte, value_out
    output logic                                 m_tlast,
    output logic [0:0]                           m_tuser      // overflow
);

    localparam int DB = sbgic_pkg::DATA_BITS;
    localparam int CW = sbgic_pkg::CODE_BITS;

    logic [sbgic_pkg::CFG_BITS-1:0]   result_bits_reg;
    logic                             m_tvalid_reg, m_tvalid_next;
    logic [sbgic_pkg::TDATA_BITS-1:0] m_tdata_reg, m_tdata_next;
    logic                             m_tlast_reg, m_tlast_next;
    logic                             m_tuser_reg, m_tuser_next;

    logic                 out_free;
    logic                 s_accept;
    logic                 enc_load;
    logic                 dec_take;
    logic                 enc_busy;
    sbgic_pkg::enc_out_t  enc_out;
    sbgic_pkg::dec_res_t  dec_res;

    assign out_free = !m_tvalid_reg || m_tready;
    assign s_tready = !enc_busy && out_free;
    assign s_accept = s_tvalid && s_tready;
    assign enc_load = s_accept && (s_tuser[0] == sbgic_pkg::OP_ENCODE);
    assign dec_take = s_accept && (s_tuser[0] == sbgic_pkg::OP_DECODE);

    sbgic_enc #(
        .VALUE_BITS(VALUE_BITS)
    ) u_enc (
        .aclk    (aclk),
        .aresetn (aresetn),
        .load    (enc_load),
        .value   (s_tdata[DB-1:0]),
        .take    (out_free),
        .out     (enc_out),
        .busy    (enc_busy)
    );

    sbgic_dec #(
        .VALUE_BITS(VALUE_BITS)
    ) u_dec (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .take        (dec_take),
        .grp         (s_tdata[DB +: sbgic_pkg::GROUP_BITS]),
        .is_last     (s_tlast),
        .result_bits (result_bits_reg),
        .res         (dec_res)
    );

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        m_tlast_next  = m_tlast_reg;
        m_tuser_next  = m_tuser_reg;
        priority if (dec_res.valid) begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = {dec_res.value, {CW{1'b0}}};
            m_tlast_next  = 1'b1;
            m_tuser_next  = dec_res.overflow;
        end else if (enc_out.valid && out_free) begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = {{DB{1'b0}}, enc_out.code};
            m_tlast_next  = enc_out.last;
            m_tuser_next  = 1'b0;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            result_bits_reg <= sbgic_pkg::RESULT_BITS_RESET;
            m_tvalid_reg    <= 1'b0;
        end else begin
            if (cfg_we) begin
                result_bits_reg <= cfg_wdata;
            end
            m_tvalid_reg <= m_tvalid_next;
        end
        m_tdata_reg <= m_tdata_next;
        m_tlast_reg <= m_tlast_next;
        m_tuser_reg <= m_tuser_next;
    end

    assign m_tvalid   = m_tvalid_reg;
    assign m_tdata    = m_tdata_reg;
    assign m_tlast    = m_tlast_reg;
    assign m_tuser[0] = m_tuser_reg;

endmodule

/* design/sbgic_chk.sv */
// port-level checker for the codec and its bind
`include "seven_bit_group_integer_codec_unit_macros.svh"

module sbgic_chk (
    input logic                             aclk,
    input logic                             aresetn,
    input logic                             s_tready,
    input logic                             m_tvalid,
    input logic                             m_tready,
    input logic [sbgic_pkg::TDATA_BITS-1:0] m_tdata,
    input logic                             m_tlast,
    input logic [0:0]                       m_tuser
);

    // a stalled result holds
    `SBGIC_ASSERT_NEXT(a_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast) && $stable(m_tuser), "stalled result changed")

    // overflow only on the final result of a decode
    `SBGIC_ASSERT_IMPLY(a_ovf_last, aclk, aresetn, m_tvalid && m_tuser[0], m_tlast && (m_tdata[7:0] == 8'h00), "overflow outside a decode result")

    // an encode byte never carries a decoded value
    `SBGIC_ASSERT_IMPLY(a_enc_clean, aclk, aresetn, m_tvalid && (m_tdata[7:0] != 8'h00), (m_tdata[71:8] == 64'h0) && !m_tuser[0], "encode byte with decode fields set")

    // a new request is only taken when the output register can take a result
    `SBGIC_ASSERT_IMPLY(a_ready_free, aclk, aresetn, s_tready && m_tvalid, m_tready, "request taken with output register full")

endmodule

bind seven_bit_group_integer_codec_unit sbgic_chk u_sbgic_chk (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
);

/* dv/seven_bit_group_integer_codec_unit_test.sv */
// testbench: directed and random encode/decode requests checked against a predictor
`timescale 1ns / 100ps

module seven_bit_group_integer_codec_unit_test;

    localparam int VBITS        = sbgic_pkg::VALUE_BITS_DEF;
    localparam int SETTLE       = 16;
    localparam int LONG_HOLD    = 300;
    localparam int QUIET_LIMIT  = 4000;
    localparam int PHASE_ITEMS  = 40;
    localparam logic [sbgic_pkg::CODE_BITS-1:0] MARK_BIT = 8'h80;

    typedef struct {
        logic [sbgic_pkg::CODE_BITS-1:0] code;
        logic [sbgic_pkg::DATA_BITS-1:0] value;
        logic                            ovf;
        logic                            last;
    } codec_result_t;

    typedef struct {
        logic                            op;
        logic [sbgic_pkg::DATA_BITS-1:0] value;
        logic [sbgic_pkg::CODE_BITS-1:0] code_in;
        logic                            is_last;
        logic                            typed;
        logic [sbgic_pkg::CODE_BITS-1:0] t_code;
        logic [sbgic_pkg::DATA_BITS-1:0] t_value;
        logic                            t_ovf;
    } directed_row_t;

    logic                             aclk;
    logic                             aresetn   = 1'b0;
    logic                             cfg_we    = 1'b0;
    logic [sbgic_pkg::CFG_BITS-1:0]   cfg_wdata = '0;
    logic                             s_tvalid  = 1'b0;
    logic                             s_tready;
    logic [sbgic_pkg::TDATA_BITS-1:0] s_tdata   = '0;   // value_in, byte_in
    logic                             s_tlast   = 1'b0;
    logic [0:0]                       s_tuser   = '0;   // opcode
    logic                             m_tvalid;
    logic                             m_tready  = 1'b0;
    logic [sbgic_pkg::TDATA_BITS-1:0] m_tdata;          // code_byte, value_out
    logic                             m_tlast;
    logic [0:0]                       m_tuser;          // overflow

    codec_result_t                   codec_results_due [$];
    logic [sbgic_pkg::DATA_BITS-1:0] decode_accum    = '0;
    int                              decode_count    = 0;
    logic [sbgic_pkg::CFG_BITS-1:0]  result_bits_cfg = sbgic_pkg::RESULT_BITS_RESET;

    bit sender_steady    = 1'b0;
    bit receiver_steady  = 1'b0;
    bit long_hold_asked  = 1'b0;
    int mismatch_count   = 0;
    int requests_sent    = 0;
    int encode_requests  = 0;
    int decode_requests  = 0;
    int results_checked  = 0;
    int widths_tried     = 1;
    int quiet_cycles     = 0;

    directed_row_t directed_requests [25] = '{
        '{sbgic_pkg::OP_ENCODE, 64'h0, 8'h00, 1'b0, 1'b1, 8'h00, 64'h0, 1'b0},
        '{sbgic_pkg::OP_ENCODE, 64'h7F, 8'h00, 1'b0, 1'b1, 8'h7F, 64'h0, 1'b0},
        '{sbgic_pkg::OP_ENCODE, 64'h80, 8'h00, 1'b0, 1'b0, 8'h00, 64'h0, 1'b0},
        '{sbgic_pkg::OP_ENCODE, 64'h3FFF, 8'h00, 1'b0, 1'b0, 8'h00, 64'h0, 1'b0},
        '{sbgic_pkg::OP_ENCODE, 64'hFFFF_FFFF_FFFF_FFFF, 8'h00, 1'b0, 1'b0, 8'h00, 64'h0, 1'b0},
        '{sbgic_pkg::OP_ENCODE, 64'h8000_0000_0000_0000, 8'h00, 1'b0, 1'b0, 8'h00, 64'h0, 1'b0},
        '{sbgic_pkg::OP_ENCODE, 64'h0123_4567_89AB_CDEF, 8'hFF, 1'b1, 1'b0, 8'h00, 64'h0, 1'b0},
        '{sbgic_pkg::OP_DECODE, 64'h0, 8'h00, 1'b1, 1'b1, 8'h00, 64'h0, 1'b0},
        '{sbgic_pkg::OP_DECODE, 64'hFFFF_FFFF_FFFF_FFFF, 8'hFF, 1'b1, 1'b1, 8'h00, 64'h7F, 1'b0},
        '{sbgic_pkg::OP_DECODE, 64'h0, 8'h01, 1'b0, 1'b0, 8'h00, 64'h0, 1'b0},
        // encode in the middle of a decode run
        '{sbgic_pkg::OP_ENCODE, 64'h80, 8'h00, 1'b0, 1'b0, 8'h00, 64'h0, 1'b0},
        '{sbgic_pkg::OP_DECODE, 64'h0, 8'h80, 1'b1, 1'b0, 8'h00, 64'h0, 1'b0},
        // leading zero groups
        '{sbgic_pkg::OP_DECODE, 64'h0, 8'h00, 1'b0, 1'b0, 8'h00, 64'h0, 1'b0},
        '{sbgic_pkg::OP_DECODE, 64'h0, 8'h80, 1'b0, 1'b0, 8'h00, 64'h0, 1'b0},
        '{sbgic_pkg::OP_DECODE, 64'h0, 8'h85, 1'b1, 1'b1, 8'h00, 64'h5, 1'b0},
        // 65 significant bits at width 64
        '{sbgic_pkg::OP_DECODE, 64'h0, 8'h02, 1'b0, 1'b0, 8'h00, 64'h0, 1'b0},
        '{sbgic_pkg::OP_DECODE, 64'h0, 8'h7F, 1'b0, 1'b0, 8'h00, 64'h0, 1'b0},
        '{sbgic_pkg::OP_DECODE, 64'h0, 8'h7F, 1'b0, 1'b0, 8'h00, 64'h0, 1'b0},
        '{sbgic_pkg::OP_DECODE, 64'h0, 8'h7F, 1'b0, 1'b0, 8'h00, 64'h0, 1'b0},
        '{sbgic_pkg::OP_DECODE, 64'h0, 8'h7F, 1'b0, 1'b0, 8'h00, 64'h0, 1'b0},
        '{sbgic_pkg::OP_DECODE, 64'h0, 8'h7F, 1'b0, 1'b0, 8'h00, 64'h0, 1'b0},
        '{sbgic_pkg::OP_DECODE, 64'h0, 8'h7F, 1'b0, 1'b0, 8'h00, 64'h0, 1'b0},
        '{sbgic_pkg::OP_DECODE, 64'h0, 8'h7F, 1'b0, 1'b0, 8'h00, 64'h0, 1'b0},
        '{sbgic_pkg::OP_DECODE, 64'h0, 8'h7F, 1'b0, 1'b0, 8'h00, 64'h0, 1'b0},
        '{sbgic_pkg::OP_DECODE, 64'h0, 8'h7F, 1'b1, 1'b1, 8'h00, 64'h7FFF_FFFF_FFFF_FFFF, 1'b1}
    };

    seven_bit_group_integer_codec_unit #(
        .VALUE_BITS(VBITS)
    ) uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_we   (cfg_we),
        .cfg_wdata(cfg_wdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    function automatic int bit_length(input logic [sbgic_pkg::DATA_BITS-1:0] v);
        int n;
        n = 0;
        for (int i = 0; i < sbgic_pkg::DATA_BITS; i++) begin
            if (v[i]) n = i + 1;
        end
        return n;
    endfunction

    function automatic logic [sbgic_pkg::DATA_BITS-1:0] width_mask(input int w);
        if (w >= sbgic_pkg::DATA_BITS) return '1;
        return (64'd1 << w) - 64'd1;
    endfunction

    function automatic void predict_codec_output(
        input logic                            op,
        input logic [sbgic_pkg::DATA_BITS-1:0] value,
        input logic [sbgic_pkg::CODE_BITS-1:0] code_in,
        input logic                            is_last,
        input bit                              queue_it
    );
        codec_result_t                   r;
        logic [sbgic_pkg::DATA_BITS-1:0] v;
        int                              groups;
        int                              g;
        int                              width;
        if (op == sbgic_pkg::OP_ENCODE) begin
            v      = value & width_mask(VBITS);
            groups = (bit_length(v) + sbgic_pkg::GROUP_BITS - 1) / sbgic_pkg::GROUP_BITS;
            if (groups == 0) groups = 1;
            for (int k = 0; k < groups; k++) begin
                r.code  = {1'b0, 7'(v >> (sbgic_pkg::GROUP_BITS * (groups - 1 - k)))};
                if (k > 0) r.code = r.code | MARK_BIT;
                r.value = '0;
                r.ovf   = 1'b0;
                r.last  = (k == groups - 1);
                if (queue_it) codec_results_due.push_back(r);
            end
        end else begin
            g            = int'(code_in[sbgic_pkg::GROUP_BITS-1:0]);
            decode_accum = (decode_accum << sbgic_pkg::GROUP_BITS) | 64'(g);
            if (decode_count == 0) begin
                if (g != 0) decode_count = bit_length(64'(g));
            end else begin
                decode_count = decode_count + sbgic_pkg::GROUP_BITS;
            end
            if (decode_count > int'(sbgic_pkg::COUNT_MAX)) begin
                decode_count = int'(sbgic_pkg::COUNT_MAX);
            end
            if (is_last) begin
                width = int'(result_bits_cfg);
                if (width == 0) width = 1;
                if (width > VBITS) width = VBITS;
                r.code  = '0;
                r.value = decode_accum & width_mask(width);
                r.ovf   = (decode_count > width);
                r.last  = 1'b1;
                if (queue_it) codec_results_due.push_back(r);
                decode_accum = '0;
                decode_count = 0;
            end
        end
    endfunction

    task automatic send_request(
        input logic                            op,
        input logic [sbgic_pkg::DATA_BITS-1:0] value,
        input logic [sbgic_pkg::CODE_BITS-1:0] code_in,
        input logic                            is_last,
        input bit                              queue_it
    );
        int gap;
        gap = sender_steady ? 0 : $urandom_range(0, 15);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {code_in, value};
        s_tlast  <= is_last;
        do @(posedge aclk); while (!s_tready);
        predict_codec_output(op, value, code_in, is_last, queue_it);
        requests_sent++;
        if (op == sbgic_pkg::OP_ENCODE) encode_requests++;
        else decode_requests++;
    endtask

    task automatic wait_results_drained();
        s_tvalid <= 1'b0;
        while (codec_results_due.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic write_result_bits(input logic [sbgic_pkg::CFG_BITS-1:0] w);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_wdata <= w;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        result_bits_cfg = w;
        widths_tried++;
    endtask

    function automatic logic [sbgic_pkg::DATA_BITS-1:0] random_word();
        return {$urandom, $urandom};
    endfunction

    task automatic send_random_encode();
        logic [sbgic_pkg::DATA_BITS-1:0] v;
        int                              len;
        v   = random_word();
        len = $urandom_range(0, sbgic_pkg::DATA_BITS);
        v   = v & width_mask(len);
        send_request(sbgic_pkg::OP_ENCODE, v, 8'($urandom_range(0, 255)), 1'($urandom), 1'b1);
    endtask

    task automatic run_random_phase(input int count);
        int                              done;
        int                              n;
        int                              zeros;
        logic [sbgic_pkg::CODE_BITS-1:0] b;
        done = 0;
        while (done < count) begin
            if ($urandom_range(0, 9) < 4) begin
                send_random_encode();
                done++;
            end else begin
                n     = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 24)
                                                    : $urandom_range(1, 11);
                zeros = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
                for (int i = 0; i < n; i++) begin
                    if ($urandom_range(0, 7) == 0) begin
                        send_random_encode();
                        done++;
                    end
                    b = 8'($urandom_range(0, 255));
                    if (i < zeros) b = b & MARK_BIT;
                    send_request(sbgic_pkg::OP_DECODE, random_word(), b, (i == n - 1), 1'b1);
                    done++;
                end
            end
        end
    endtask

    // result side: random stall per result, one long hold on request
    initial begin : result_sink
        int stall;
        do @(posedge aclk); while (!aresetn);
        forever begin
            if (long_hold_asked) begin
                long_hold_asked = 1'b0;
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge aclk);
            end
            stall = receiver_steady ? 0 : $urandom_range(0, 15);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    always @(posedge aclk) begin : result_check
        codec_result_t due;
        if (aresetn && m_tvalid && m_tready) begin
            results_checked++;
            if (codec_results_due.size() == 0) begin
                $error("unexpected result: code_byte %h value_out %h",
                       m_tdata[sbgic_pkg::CODE_BITS-1:0],
                       m_tdata[sbgic_pkg::TDATA_BITS-1:sbgic_pkg::CODE_BITS]);
                mismatch_count++;
            end else begin
                due = codec_results_due.pop_front();
                if (m_tdata[sbgic_pkg::CODE_BITS-1:0] !== due.code) begin
                    $error("code_byte: expected %h actual %h", due.code,
                           m_tdata[sbgic_pkg::CODE_BITS-1:0]);
                    mismatch_count++;
                end
                if (m_tdata[sbgic_pkg::TDATA_BITS-1:sbgic_pkg::CODE_BITS] !== due.value) begin
                    $error("value_out: expected %h actual %h", due.value,
                           m_tdata[sbgic_pkg::TDATA_BITS-1:sbgic_pkg::CODE_BITS]);
                    mismatch_count++;
                end
                if (m_tuser[0] !== due.ovf) begin
                    $error("overflow: expected %b actual %b", due.ovf, m_tuser[0]);
                    mismatch_count++;
                end
                if (m_tlast !== due.last) begin
                    $error("last: expected %b actual %b", due.last, m_tlast);
                    mismatch_count++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("watchdog: no progress for %0d cycles", QUIET_LIMIT);
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    initial begin : stimulus
        directed_row_t                  row;
        logic [sbgic_pkg::CFG_BITS-1:0] widths [8];
        widths = '{7'd1, 7'd0, 7'd127, 7'd63, 7'd8, 7'd65, 7'd33, 7'd64};
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed rows at the reset width
        for (int i = 0; i < $size(directed_requests); i++) begin
            row = directed_requests[i];
            send_request(row.op, row.value, row.code_in, row.is_last, !row.typed);
            if (row.typed) begin
                codec_results_due.push_back('{row.t_code, row.t_value, row.t_ovf, 1'b1});
            end
        end
        wait_results_drained();

        for (int p = 0; p < $size(widths); p++) begin
            write_result_bits(widths[p]);
            sender_steady   = (p == 2) || (p == 4) || (p == 5);
            receiver_steady = (p == 3) || (p == 5);
            // back-pressure: sink holds off while the source keeps pushing
            if (p == 4) long_hold_asked = 1'b1;
            run_random_phase(PHASE_ITEMS);
            wait_results_drained();
        end

        $display("covered %0d requests (%0d encode, %0d decode byte), %0d results checked",
                 requests_sent, encode_requests, decode_requests, results_checked);
        $display("across %0d result widths, including 0, 1, 64 and above", widths_tried);
        if (mismatch_count == 0 && codec_results_due.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
